FILE: rtl/core/cv3_pkg.sv
// Shared types and constants for the 3x3 streaming convolution block.
package cv3_pkg;

    localparam int PIX_W      = 16;  // unsigned Q8.8 pixel
    localparam int COEF_W     = 16;  // signed coefficient
    localparam int OUT_W      = 24;  // signed Q16.8 result
    localparam int POS_W      = 11;  // output row / column
    localparam int SIZE_W     = 12;  // width / height registers
    localparam int CFG_W      = 48;  // widest register
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_MAX_HEIGHT     = 2048;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam int MIN_SIZE = 3;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);
    localparam logic [CFG_W-1:0]  COEF0_RST  = CFG_W'(0);
    localparam logic [CFG_W-1:0]  COEF1_RST  = CFG_W'(48'h0000_1000_0000);
    localparam logic [CFG_W-1:0]  COEF2_RST  = CFG_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_COEF0  = 3'd2,
        REG_COEF1  = 3'd3,
        REG_COEF2  = 3'd4
    } cfg_idx_t;

    // taps[k][l]: k = 0 newest row, l = 0 newest column
    typedef logic [2:0][2:0][PIX_W-1:0] taps_t;
    typedef logic [2:0][CFG_W-1:0]      coef_rows_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } pos_t;

endpackage

FILE: rtl/core/cv3_window.sv
// Position counters, line buffer memory and 3x3 window registers.
module cv3_window import cv3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_lim,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height_lim,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [PIX_W-1:0]                   in_pixel,
    input  logic                               in_sof,
    output logic                               tap_valid,
    input  logic                               tap_ready,
    output taps_t                              taps,
    output pos_t                               tap_pos
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = 2 * PIX_W;

    logic [AW-1:0] col_reg, col_next, c_cur;
    logic [RW-1:0] row_reg, row_next, r_cur;
    logic          emit_cur;
    pos_t          pos_cur;

    logic          s1_valid_reg, s1_emit_reg, s1_fwd_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [AW-1:0] s1_addr_reg;
    pos_t          s1_pos_reg;
    logic [LW-1:0] s1_fwd_data_reg, rd_data_reg, line_cur, line_wr;

    logic [2:0][PIX_W-1:0] win_near_reg, win_far_reg, col0;
    logic          s1_en, s1_fire, accept;

    // entry c: [15:0] row r-1, [31:16] row r-2
    logic [LW-1:0] line_mem [MAX_WIDTH];

    always_comb
    begin
        c_cur = in_sof ? '0 : col_reg;
        r_cur = in_sof ? '0 : row_reg;
        emit_cur = (32'(r_cur) >= 32'd2) && (32'(c_cur) >= 32'd2) &&
                   (32'(r_cur) < 32'(height_lim)) && (32'(c_cur) < 32'(width_lim));
        pos_cur.row  = POS_W'(32'(r_cur) - 32'd1);
        pos_cur.col  = POS_W'(32'(c_cur) - 32'd1);
        pos_cur.last = (32'(r_cur) == 32'(height_lim) - 32'd1) &&
                       (32'(c_cur) == 32'(width_lim) - 32'd1);
        if (32'(c_cur) + 32'd1 >= 32'(width_lim))
        begin
            col_next = '0;
            row_next = (32'(r_cur) + 32'd1 >= 32'(height_lim)) ? '0 :
                       RW'(32'(r_cur) + 32'd1);
        end
        else
        begin
            col_next = AW'(32'(c_cur) + 32'd1);
            row_next = r_cur;
        end
    end

    // a non-emitting beat leaves stage 1 without waiting on the MAC
    assign s1_en    = !s1_valid_reg || !s1_emit_reg || tap_ready;
    assign in_ready = s1_en;
    assign accept   = in_valid && s1_en;
    assign s1_fire  = s1_valid_reg && s1_en;

    assign line_cur = s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
    assign line_wr  = {line_cur[PIX_W-1:0], s1_px_reg};

    always_comb
    begin
        col0[0] = s1_px_reg;
        col0[1] = line_cur[PIX_W-1:0];
        col0[2] = line_cur[LW-1:PIX_W];
        for (int k = 0; k < 3; k++)
        begin
            taps[k][0] = col0[k];
            taps[k][1] = win_near_reg[k];
            taps[k][2] = win_far_reg[k];
        end
    end

    assign tap_valid = s1_valid_reg && s1_emit_reg;
    assign tap_pos   = s1_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            win_near_reg <= '0;
            win_far_reg  <= '0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                s1_emit_reg <= emit_cur;
                // same entry written by the beat leaving stage 1: bypass the memory
                s1_fwd_reg  <= s1_fire && (s1_addr_reg == c_cur);
            end
            if (s1_fire)
            begin
                win_far_reg  <= win_near_reg;
                win_near_reg <= col0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= in_pixel;
            s1_addr_reg     <= c_cur;
            s1_pos_reg      <= pos_cur;
            s1_fwd_data_reg <= line_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            line_mem[s1_addr_reg] <= line_wr;
        if (accept)
            rd_data_reg <= line_mem[c_cur];
    end

endmodule

FILE: rtl/core/cv3_mac.sv
// Multiply-accumulate pipeline: nine products, row sums, rounding, saturation.
module cv3_mac import cv3_pkg::*; #(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  coef_rows_t              coefs,
    input  logic                    tap_valid,
    output logic                    tap_ready,
    input  taps_t                   taps,
    input  pos_t                    tap_pos,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] out_value,
    output pos_t                    out_pos,
    output logic                    out_clipped
);

    localparam int PROD_W = PIX_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 4;

    localparam logic signed [SUM_W-1:0] ROUND  = SUM_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << (OUT_W - 1));

    function automatic logic signed [PROD_W-1:0] px_mul(
        input logic [PIX_W-1:0]  px,
        input logic [COEF_W-1:0] cf
    );
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = $signed(PROD_W'(px));
        b = PROD_W'($signed(cf));
        return a * b;
    endfunction

    logic p_valid_reg, r_valid_reg, t_valid_reg, out_valid_reg;
    logic p_en, r_en, t_en, out_en;

    logic [2:0][2:0][PROD_W-1:0] prod_reg, prod_next;
    logic [2:0][SUM_W-1:0]       rsum_reg, rsum_next;
    logic signed [SUM_W-1:0]     tot_reg, tot_next, shifted;
    pos_t                        p_pos_reg, r_pos_reg, t_pos_reg, out_pos_reg;
    logic signed [OUT_W-1:0]     out_value_reg, out_value_next;
    logic                        out_clip_reg, out_clip_next;

    assign out_en    = !out_valid_reg || out_ready;
    assign t_en      = !t_valid_reg || out_en;
    assign r_en      = !r_valid_reg || t_en;
    assign p_en      = !p_valid_reg || r_en;
    assign tap_ready = p_en;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int l = 0; l < 3; l++)
                prod_next[k][l] = px_mul(taps[k][l], coefs[k][COEF_W*l +: COEF_W]);
            rsum_next[k] = SUM_W'($signed(prod_reg[k][0])) +
                           SUM_W'($signed(prod_reg[k][1])) +
                           SUM_W'($signed(prod_reg[k][2]));
        end
        tot_next = $signed(rsum_reg[0]) + $signed(rsum_reg[1]) +
                   $signed(rsum_reg[2]) + ROUND;
        shifted = tot_reg >>> COEF_FRAC_BITS;
        if (shifted > SAT_HI)
        begin
            out_value_next = OUT_W'(SAT_HI);
            out_clip_next  = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            out_value_next = OUT_W'(SAT_LO);
            out_clip_next  = 1'b1;
        end
        else
        begin
            out_value_next = OUT_W'(shifted);
            out_clip_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            t_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_en)
                p_valid_reg <= tap_valid;
            if (r_en)
                r_valid_reg <= p_valid_reg;
            if (t_en)
                t_valid_reg <= r_valid_reg;
            if (out_en)
                out_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_en)
        begin
            prod_reg  <= prod_next;
            p_pos_reg <= tap_pos;
        end
        if (r_en)
        begin
            rsum_reg  <= rsum_next;
            r_pos_reg <= p_pos_reg;
        end
        if (t_en)
        begin
            tot_reg   <= tot_next;
            t_pos_reg <= r_pos_reg;
        end
        if (out_en)
        begin
            out_value_reg <= out_value_next;
            out_clip_reg  <= out_clip_next;
            out_pos_reg   <= t_pos_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_pos     = out_pos_reg;
    assign out_clipped = out_clip_reg;

endmodule

FILE: rtl/core/convolution_3x3_stream_unit.sv
// Top level of the 3x3 streaming convolution: configuration registers and stream ports.
//
// Input stream (s_*): one grayscale Q8.8 pixel per beat in raster order; s_tuser
// marks the first pixel of a frame and restarts the row and column counters.
// Output stream (m_*): one beat per interior pixel (row and column both at least
// one and below size minus one), carrying the signed Q16.8 convolution, its
// position, m_tlast on the last interior pixel of a frame and m_tuser when the
// result was saturated. Border positions produce no output beat.
// Configuration: cfg_we writes cfg_data to register cfg_addr (0 width, 1 height,
// 2..4 coefficient rows); write only while no beat is in flight.
// Throughput: one pixel per clock, limited by the single line buffer memory that
// is read once and written once per pixel (both rows share one 32-bit entry).
// Results pass through the MAC's product, row-sum, total and output registers.
// A stalled m_tready fills the four MAC stages; the next result-producing pixel
// then waits in the window stage and s_tready drops (five results held). Border
// pixels keep flowing until then. No beat is lost, and bubbles collapse as soon
// as the sink takes data again.
// Reset clears counters, window and pipeline valids and loads default sizes
// (640 x 480) and an identity kernel; the line buffer is not cleared.
module convolution_3x3_stream_unit import cv3_pkg::*; #(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] pixel_value
    input  logic                  s_tuser,   // [0] start_of_frame
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [23:0] filtered_value, [34:24] out_row,
                                             // [45:35] out_col, [47:46] zero
    output logic                  m_tlast,   // last_of_frame
    output logic                  m_tuser,   // [0] clipped
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [SIZE_W-1:0] width_reg, height_reg;
    coef_rows_t        coef_reg;
    logic [WW-1:0]     width_lim;
    logic [HW-1:0]     height_lim;

    logic              tap_valid, tap_ready;
    taps_t             taps;
    pos_t              tap_pos, out_pos;
    logic signed [OUT_W-1:0] out_value;
    logic              out_clipped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            coef_reg[0] <= COEF0_RST;
            coef_reg[1] <= COEF1_RST;
            coef_reg[2] <= COEF2_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WIDTH:  width_reg   <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: height_reg  <= cfg_data[SIZE_W-1:0];
                REG_COEF0:  coef_reg[0] <= cfg_data;
                REG_COEF1:  coef_reg[1] <= cfg_data;
                REG_COEF2:  coef_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // clamp frame size into MIN_SIZE..MAX
    always_comb
    begin
        if (32'(width_reg) < 32'(MIN_SIZE))
            width_lim = WW'(MIN_SIZE);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            width_lim = WW'(MAX_WIDTH);
        else
            width_lim = WW'(width_reg);

        if (32'(height_reg) < 32'(MIN_SIZE))
            height_lim = HW'(MIN_SIZE);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            height_lim = HW'(MAX_HEIGHT);
        else
            height_lim = HW'(height_reg);
    end

    cv3_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pixel   (s_tdata[PIX_W-1:0]),
        .in_sof     (s_tuser),
        .tap_valid  (tap_valid),
        .tap_ready  (tap_ready),
        .taps       (taps),
        .tap_pos    (tap_pos)
    );

    cv3_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .coefs       (coef_reg),
        .tap_valid   (tap_valid),
        .tap_ready   (tap_ready),
        .taps        (taps),
        .tap_pos     (tap_pos),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (out_value),
        .out_pos     (out_pos),
        .out_clipped (out_clipped)
    );

    assign m_tdata = {2'b00, out_pos.col, out_pos.row, out_value};
    assign m_tlast = out_pos.last;
    assign m_tuser = out_clipped;

endmodule
